@@ hdl/npts_pkg.sv @@
// Shared types and constants for the nearest point table search block.
// No dependencies; imported by npts_dist, nearest_point_table_search_core and the testbench files.
package npts_pkg;

	localparam int DIST_W    = 34;
	localparam int IDX_W     = 10;
	localparam int ENTRIES_W = 11;
	localparam int GROUP_W   = 5;
	localparam int REG_IDX_W = 2;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GROUP_SIZE     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_GROUP_USED     = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_DISTANCE_LIMIT = 2'd3;

	localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 11'd1024;
	localparam logic [GROUP_W-1:0]   GROUP_RESET   = 5'd8;
	localparam logic [DIST_W-1:0]    LIMIT_RESET   = 34'd2048000000;

	localparam logic [1:0] DRAIN_LAST = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN,
		S_DRAIN,
		S_REPLY
	} npts_state_t;

endpackage

@@ hdl/npts_dist.sv @@
// Squared distance unit: three stages, absolute difference, square, sum with saturation.
// Depends on npts_pkg.
module npts_dist #(
	parameter int COORD_WIDTH = 16,
	parameter int ADDR_W      = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [ADDR_W-1:0]             in_addr,
	input  logic [3*COORD_WIDTH-1:0]      entry,
	input  logic [3*COORD_WIDTH-1:0]      query,
	output logic                          out_valid,
	output logic [ADDR_W-1:0]             out_addr,
	output logic [npts_pkg::DIST_W-1:0]   out_dist
);
	import npts_pkg::*;

	localparam int AD_W  = COORD_WIDTH + 1;
	localparam int SQ_W  = 2 * AD_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int EXT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W + 1;
	localparam logic [EXT_W-1:0] SAT = EXT_W'(DIST_MAX);

	logic [AD_W-1:0]   ad [3];
	logic [AD_W-1:0]   ad_s1 [3];
	logic [SQ_W-1:0]   sq_s2 [3];
	logic [EXT_W-1:0]  sum;
	logic              valid_s1, valid_s2, valid_s3;
	logic [ADDR_W-1:0] addr_s1, addr_s2, addr_s3;
	logic [DIST_W-1:0] dist_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [AD_W-1:0] d;
			d = $signed({entry[i*COORD_WIDTH+COORD_WIDTH-1], entry[i*COORD_WIDTH +: COORD_WIDTH]})
				- $signed({query[i*COORD_WIDTH+COORD_WIDTH-1], query[i*COORD_WIDTH +: COORD_WIDTH]});
			ad[i] = d[AD_W-1] ? (~d + AD_W'(1)) : d;
		end
	end

	assign sum = EXT_W'(sq_s2[0]) + EXT_W'(sq_s2[1]) + EXT_W'(sq_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= in_addr;
		addr_s2 <= addr_s1;
		addr_s3 <= addr_s2;
		for (int i = 0; i < 3; i++) begin
			ad_s1[i] <= ad[i];
			sq_s2[i] <= SQ_W'(ad_s1[i]) * SQ_W'(ad_s1[i]);
		end
		dist_s3 <= (sum > SAT) ? DIST_MAX : sum[DIST_W-1:0];
	end

	assign out_valid = valid_s3;
	assign out_addr  = addr_s3;
	assign out_dist  = dist_s3;

endmodule

@@ hdl/nearest_point_table_search_core.sv @@
// Nearest point table search: location table, scan sequencer and best-match tracking.
// Depends on npts_pkg and npts_dist.
//
// Usage: an item is a transfer at a rising edge with start high and busy low. cmd selects
// a table load (entry_index, coord_x/y/z) or a nearest-point query (coord_x/y/z).
// A load produces no result; an entry_index of TABLE_DEPTH or more is wrapped by
// subtracting TABLE_DEPTH until it fits before the table is written.
// A query scans addresses 0 to min(entries_in_use, TABLE_DEPTH) - 1, one address per
// cycle through the single memory read port and the shared distance pipeline, then
// drains the pipeline. done is high for exactly one cycle with found, exact,
// nearest_index and nearest_sq_distance. busy is high from the transfer until after done.
// Configuration: wr_en, wr_index and wr_data write one register per edge; write only
// while busy is low. The receiver cannot stall; results are offered once.
// Reset clears the registers to their reset values and the sequencer to idle; the
// table is not cleared and must be loaded before it is searched.
module nearest_point_table_search_core #(
	parameter int TABLE_DEPTH = 1024,
	parameter int COORD_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cmd,
	input  logic [npts_pkg::IDX_W-1:0]        entry_index,
	input  logic signed [COORD_WIDTH-1:0]     coord_x,
	input  logic signed [COORD_WIDTH-1:0]     coord_y,
	input  logic signed [COORD_WIDTH-1:0]     coord_z,
	input  logic                              wr_en,
	input  logic [npts_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [npts_pkg::DIST_W-1:0]       wr_data,
	output logic                              done,
	output logic                              found,
	output logic                              exact,
	output logic [npts_pkg::IDX_W-1:0]        nearest_index,
	output logic [npts_pkg::DIST_W-1:0]       nearest_sq_distance
);
	import npts_pkg::*;

	localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int DW_C  = $clog2(TABLE_DEPTH + 1);
	localparam int CNT_W = (DW_C > ENTRIES_W) ? DW_C : ENTRIES_W;
	localparam int ENT_W = 3 * COORD_WIDTH;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	npts_state_t state_q, state_d;

	logic [ENTRIES_W-1:0] entries_q;
	logic [GROUP_W-1:0]   group_size_q, group_used_q;
	logic [DIST_W-1:0]    limit_q;

	logic [ENT_W-1:0]  mem [TABLE_DEPTH];
	logic [ENT_W-1:0]  rd_s1;
	logic              issue_valid_s1;
	logic [CNT_W-1:0]  issue_addr_s1;

	logic [ENT_W-1:0]  query_q;
	logic [CNT_W-1:0]  load_addr_q, scan_addr_q, count_q, entries_ext;
	logic [GROUP_W-1:0] pos_q, gsize;
	logic [1:0]        drain_q;

	logic              found_q, exact_q;
	logic [DIST_W-1:0] best_d_q, bound;
	logic [IDX_W-1:0]  best_i_q;

	logic              dist_valid;
	logic [CNT_W-1:0]  dist_addr;
	logic [DIST_W-1:0] dist_value;

	logic accept, load_fits;

	assign accept      = start && (state_q == S_IDLE);
	assign load_fits   = load_addr_q < DEPTH_C;
	assign entries_ext = CNT_W'(entries_q);
	assign gsize       = (group_size_q == '0) ? GROUP_W'(1) : group_size_q;
	assign bound       = found_q ? best_d_q : limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q    <= ENTRIES_RESET;
			group_size_q <= GROUP_RESET;
			group_used_q <= GROUP_RESET;
			limit_q      <= LIMIT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_ENTRIES_IN_USE: entries_q    <= wr_data[ENTRIES_W-1:0];
				REG_GROUP_SIZE:     group_size_q <= wr_data[GROUP_W-1:0];
				REG_GROUP_USED:     group_used_q <= wr_data[GROUP_W-1:0];
				REG_DISTANCE_LIMIT: limit_q      <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = (cmd == CMD_LOAD) ? S_LOAD : S_SCAN;
			end
			S_LOAD: begin
				if (load_fits) state_d = S_IDLE;
			end
			S_SCAN: begin
				if (scan_addr_q >= count_q) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (drain_q == DRAIN_LAST) state_d = S_REPLY;
			end
			S_REPLY: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		busy                = (state_q != S_IDLE);
		done                = (state_q == S_REPLY);
		found               = found_q;
		exact               = exact_q;
		nearest_index       = best_i_q;
		nearest_sq_distance = best_d_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q    <= '0;
			count_q        <= '0;
			pos_q          <= '0;
			drain_q        <= '0;
			issue_valid_s1 <= 1'b0;
			found_q        <= 1'b0;
			exact_q        <= 1'b0;
		end else begin
			issue_valid_s1 <= 1'b0;
			if (accept) begin
				scan_addr_q <= '0;
				pos_q       <= '0;
				drain_q     <= '0;
				count_q     <= (entries_ext > DEPTH_C) ? DEPTH_C : entries_ext;
				found_q     <= 1'b0;
				exact_q     <= 1'b0;
			end else begin
				if (state_q == S_SCAN && scan_addr_q < count_q) begin
					issue_valid_s1 <= (pos_q < group_used_q) && !exact_q;
					scan_addr_q    <= scan_addr_q + CNT_W'(1);
					pos_q          <= (pos_q + GROUP_W'(1) >= gsize) ? '0 : pos_q + GROUP_W'(1);
				end
				if (state_q == S_DRAIN) drain_q <= drain_q + 2'd1;
				if (dist_valid && !exact_q) begin
					if (dist_value == '0) begin
						found_q <= 1'b1;
						exact_q <= 1'b1;
					end else if (dist_value < bound) begin
						found_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			query_q     <= {coord_z, coord_y, coord_x};
			load_addr_q <= CNT_W'(entry_index);
			best_d_q    <= '0;
			best_i_q    <= '0;
		end else begin
			if (state_q == S_LOAD && !load_fits) load_addr_q <= load_addr_q - DEPTH_C;
			if (dist_valid && !exact_q && (dist_value == '0 || dist_value < bound)) begin
				best_d_q <= dist_value;
				best_i_q <= dist_addr[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && load_fits) mem[load_addr_q[AW-1:0]] <= query_q;
		rd_s1         <= mem[scan_addr_q[AW-1:0]];
		issue_addr_s1 <= scan_addr_q;
	end

	npts_dist #(
		.COORD_WIDTH (COORD_WIDTH),
		.ADDR_W      (CNT_W)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (issue_valid_s1),
		.in_addr   (issue_addr_s1),
		.entry     (rd_s1),
		.query     (query_q),
		.out_valid (dist_valid),
		.out_addr  (dist_addr),
		.out_dist  (dist_value)
	);

	a_done_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_DRAIN)
		else $error("result strobe without a finished drain");

	a_exact_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && exact |-> found && nearest_sq_distance == '0)
		else $error("exact result with nonzero distance");

	a_inexact_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && found && !exact |-> nearest_sq_distance != '0)
		else $error("inexact result with zero distance");

	a_best_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && $past(found_q) |-> best_d_q <= $past(best_d_q))
		else $error("best distance grew during a scan");

	a_load_returns: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD && load_fits |=> state_q == S_IDLE)
		else $error("load did not complete");

endmodule

@@ tb/sv/npts_search_scoreboard.sv @@
// Scoreboard for the nearest point table search core: mirrors register writes and
// table loads, predicts each search result and compares it with the block's output.
// Depends on npts_pkg.
module npts_search_scoreboard #(
	parameter int TABLE_DEPTH = 1024,
	parameter int COORD_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic                              cmd,
	input  logic [npts_pkg::IDX_W-1:0]        entry_index,
	input  logic signed [COORD_WIDTH-1:0]     coord_x,
	input  logic signed [COORD_WIDTH-1:0]     coord_y,
	input  logic signed [COORD_WIDTH-1:0]     coord_z,
	input  logic                              wr_en,
	input  logic [npts_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [npts_pkg::DIST_W-1:0]       wr_data,
	input  logic                              done,
	input  logic                              found,
	input  logic                              exact,
	input  logic [npts_pkg::IDX_W-1:0]        nearest_index,
	input  logic [npts_pkg::DIST_W-1:0]       nearest_sq_distance,
	output int                                mismatch_count,
	output int                                searches_open,
	output int                                searches_checked,
	output int                                searches_hit,
	output int                                searches_exact
);
	timeunit 1ns;
	timeprecision 1ps;
	import npts_pkg::*;

	typedef struct packed {
		logic              found;
		logic              exact;
		logic [IDX_W-1:0]  index;
		logic [DIST_W-1:0] sq_dist;
	} match_t;

	logic signed [COORD_WIDTH-1:0] point_x [TABLE_DEPTH];
	logic signed [COORD_WIDTH-1:0] point_y [TABLE_DEPTH];
	logic signed [COORD_WIDTH-1:0] point_z [TABLE_DEPTH];

	logic [ENTRIES_W-1:0] scan_count;
	logic [GROUP_W-1:0]   group_len;
	logic [GROUP_W-1:0]   group_take;
	logic [DIST_W-1:0]    dist_limit;

	match_t expected_matches [$];
	int fails;
	int checked;
	int hits;
	int exacts;

	function automatic match_t nearest_match(logic signed [COORD_WIDTH-1:0] qx,
			logic signed [COORD_WIDTH-1:0] qy, logic signed [COORD_WIDTH-1:0] qz);
		match_t best;
		int span;
		int stride;
		longint dx;
		longint dy;
		longint dz;
		logic [63:0] d;
		best = '0;
		span = (int'(scan_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_count);
		stride = (group_len == 0) ? 1 : int'(group_len);
		for (int a = 0; a < span && !best.exact; a++) begin
			if ((a % stride) < int'(group_take)) begin
				dx = longint'(point_x[a]) - longint'(qx);
				dy = longint'(point_y[a]) - longint'(qy);
				dz = longint'(point_z[a]) - longint'(qz);
				d = dx * dx + dy * dy + dz * dz;
				if (d > 64'(DIST_MAX))
					d = 64'(DIST_MAX);
				if (d == 0) begin
					best.found = 1'b1;
					best.exact = 1'b1;
					best.index = IDX_W'(a);
					best.sq_dist = '0;
				end else if (d < (best.found ? 64'(best.sq_dist) : 64'(dist_limit))) begin
					best.found = 1'b1;
					best.index = IDX_W'(a);
					best.sq_dist = d[DIST_W-1:0];
				end
			end
		end
		return best;
	endfunction

	task automatic report_mismatch(string what, match_t want, match_t got);
		fails++;
		if (fails <= 10)
			$display("%0t ns %s: want found=%0b exact=%0b index=%0d dist=%0d,",
				$time, what, want.found, want.exact, want.index, want.sq_dist,
				" got found=%0b exact=%0b index=%0d dist=%0d",
				got.found, got.exact, got.index, got.sq_dist);
	endtask

	always @(posedge clk or negedge arst_n) begin
		match_t want;
		match_t got;
		int slot;
		if (!arst_n) begin
			scan_count = ENTRIES_RESET;
			group_len = GROUP_RESET;
			group_take = GROUP_RESET;
			dist_limit = LIMIT_RESET;
			expected_matches.delete();
			fails = 0;
			checked = 0;
			hits = 0;
			exacts = 0;
		end else begin
			if (done) begin
				got = {found, exact, nearest_index, nearest_sq_distance};
				if (expected_matches.size() == 0) begin
					report_mismatch("result with no search outstanding", '0, got);
				end else begin
					want = expected_matches.pop_front();
					checked++;
					if (want.found)
						hits++;
					if (want.exact)
						exacts++;
					if (got !== want)
						report_mismatch("search result mismatch", want, got);
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_ENTRIES_IN_USE: scan_count = wr_data[ENTRIES_W-1:0];
					REG_GROUP_SIZE:     group_len = wr_data[GROUP_W-1:0];
					REG_GROUP_USED:     group_take = wr_data[GROUP_W-1:0];
					REG_DISTANCE_LIMIT: dist_limit = wr_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (cmd == CMD_LOAD) begin
					slot = int'(entry_index) % TABLE_DEPTH;
					point_x[slot] = coord_x;
					point_y[slot] = coord_y;
					point_z[slot] = coord_z;
				end else begin
					expected_matches.push_back(nearest_match(coord_x, coord_y, coord_z));
				end
			end
		end
		mismatch_count <= fails;
		searches_open <= expected_matches.size();
		searches_checked <= checked;
		searches_hit <= hits;
		searches_exact <= exacts;
	end

endmodule

@@ tb/sv/nearest_point_table_search_core_tb.sv @@
// Top of the nearest point table search testbench: clock, reset, register settings,
// table loads and search transfers; the verdict comes from npts_search_scoreboard.
// Depends on npts_pkg, npts_search_scoreboard and nearest_point_table_search_core.
module nearest_point_table_search_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import npts_pkg::*;

	localparam int DEPTH = 1024;
	localparam int CW = 16;
	localparam logic signed [CW-1:0] PT_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] PT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam int C_MIN = -(1 << (CW-1));
	localparam int C_MAX = (1 << (CW-1)) - 1;
	localparam int PHASE_ITEMS = 30;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  cmd = CMD_LOAD;
	logic [IDX_W-1:0]      entry_index = '0;
	logic signed [CW-1:0]  coord_x = '0;
	logic signed [CW-1:0]  coord_y = '0;
	logic signed [CW-1:0]  coord_z = '0;
	logic                  wr_en = 1'b0;
	logic [REG_IDX_W-1:0]  wr_index = '0;
	logic [DIST_W-1:0]     wr_data = '0;
	logic                  done;
	logic                  found;
	logic                  exact;
	logic [IDX_W-1:0]      nearest_index;
	logic [DIST_W-1:0]     nearest_sq_distance;

	int mismatch_count;
	int searches_open;
	int searches_checked;
	int searches_hit;
	int searches_exact;

	logic signed [CW-1:0] shadow_x [DEPTH];
	logic signed [CW-1:0] shadow_y [DEPTH];
	logic signed [CW-1:0] shadow_z [DEPTH];
	bit                   loaded [DEPTH];
	int scan_span;
	int scan_step;
	int scan_take;
	int idle_pct = 0;
	int loads_sent = 0;
	int searches_sent = 0;
	int settings_used = 0;

	nearest_point_table_search_core #(
		.TABLE_DEPTH(DEPTH),
		.COORD_WIDTH(CW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.entry_index(entry_index),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.done(done),
		.found(found),
		.exact(exact),
		.nearest_index(nearest_index),
		.nearest_sq_distance(nearest_sq_distance)
	);

	npts_search_scoreboard #(
		.TABLE_DEPTH(DEPTH),
		.COORD_WIDTH(CW)
	) i_scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.entry_index(entry_index),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.done(done),
		.found(found),
		.exact(exact),
		.nearest_index(nearest_index),
		.nearest_sq_distance(nearest_sq_distance),
		.mismatch_count(mismatch_count),
		.searches_open(searches_open),
		.searches_checked(searches_checked),
		.searches_hit(searches_hit),
		.searches_exact(searches_exact)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic bit is_scanned(int a);
		return a < scan_span && (a % scan_step) < scan_take;
	endfunction

	function automatic logic signed [CW-1:0] pick_coord();
		int sel;
		sel = $urandom_range(99);
		if (sel < 12) begin
			case ($urandom_range(3))
				0: return PT_MIN;
				1: return PT_MAX;
				2: return '0;
				default: return '1;
			endcase
		end
		if (sel < 45)
			return CW'($urandom_range(128) - 64);
		return CW'($urandom);
	endfunction

	function automatic logic signed [CW-1:0] nudge(logic signed [CW-1:0] v);
		int t;
		t = int'(v) + int'($urandom_range(6)) - 3;
		if (t > C_MAX)
			t = C_MAX;
		if (t < C_MIN)
			t = C_MIN;
		return CW'(t);
	endfunction

	function automatic logic [DIST_W-1:0] pick_limit();
		case ($urandom_range(5))
			0: return '0;
			1: return DIST_MAX;
			2: return LIMIT_RESET;
			3: return DIST_W'($urandom_range(40));
			4: return DIST_W'($urandom_range(200000));
			default: return DIST_W'({$urandom, $urandom});
		endcase
	endfunction

	task automatic idle_gap();
		int n;
		n = 0;
		while ($urandom_range(99) < idle_pct)
			n++;
		if (idle_pct != 0 && $urandom_range(9) == 0)
			n += $urandom_range(60);
		repeat (n) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic issue(logic op, int addr, logic signed [CW-1:0] x,
			logic signed [CW-1:0] y, logic signed [CW-1:0] z);
		idle_gap();
		start <= 1'b1;
		cmd <= op;
		entry_index <= IDX_W'(addr);
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		// hold start until the block takes the transfer
		do
			@(posedge clk);
		while (busy);
		if (op == CMD_LOAD) begin
			shadow_x[addr] = x;
			shadow_y[addr] = y;
			shadow_z[addr] = z;
			loaded[addr] = 1'b1;
			loads_sent++;
		end else begin
			searches_sent++;
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		while (searches_open != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		while (busy || searches_open != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DIST_W-1:0] value, int width);
		logic [DIST_W-1:0] junk;
		junk = DIST_W'({$urandom, $urandom});
		if ($urandom_range(3) == 0)
			value = value | (junk & ~((DIST_W'(1) << width) - 1));
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
	endtask

	task automatic fill_gaps();
		for (int a = 0; a < scan_span; a++)
			if (is_scanned(a) && !loaded[a])
				issue(CMD_LOAD, a, pick_coord(), pick_coord(), pick_coord());
	endtask

	task automatic apply_settings(int entries, int gsize, int gused, logic [DIST_W-1:0] limit);
		settle();
		write_reg(REG_ENTRIES_IN_USE, DIST_W'(entries), ENTRIES_W);
		write_reg(REG_GROUP_SIZE, DIST_W'(gsize), GROUP_W);
		write_reg(REG_GROUP_USED, DIST_W'(gused), GROUP_W);
		write_reg(REG_DISTANCE_LIMIT, limit, DIST_W);
		wr_en <= 1'b0;
		scan_span = (entries > DEPTH) ? DEPTH : entries;
		scan_step = (gsize == 0) ? 1 : gsize;
		scan_take = gused;
		settings_used++;
		fill_gaps();
	endtask

	task automatic random_load();
		int a;
		int src;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		if (scan_span > 0 && $urandom_range(9) < 7)
			a = $urandom_range(scan_span - 1);
		else
			a = $urandom_range(DEPTH - 1);
		x = pick_coord();
		y = pick_coord();
		z = pick_coord();
		src = $urandom_range(DEPTH - 1);
		// copy an existing point, sometimes nudged, to make ties and near neighbours
		if ($urandom_range(9) < 3 && loaded[src]) begin
			x = shadow_x[src];
			y = shadow_y[src];
			z = shadow_z[src];
			if ($urandom_range(1) == 1) begin
				x = nudge(x);
				y = nudge(y);
				z = nudge(z);
			end
		end
		issue(CMD_LOAD, a, x, y, z);
	endtask

	task automatic random_search();
		int a;
		int mode;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		mode = $urandom_range(99);
		x = pick_coord();
		y = pick_coord();
		z = pick_coord();
		if (mode < 65 && scan_span > 0 && scan_take > 0) begin
			a = $urandom_range(scan_span - 1);
			for (int tries = 0; tries < 32 && !is_scanned(a); tries++)
				a = $urandom_range(scan_span - 1);
			if (is_scanned(a)) begin
				x = shadow_x[a];
				y = shadow_y[a];
				z = shadow_z[a];
				if (mode >= 35) begin
					x = nudge(x);
					y = nudge(y);
					z = nudge(z);
				end
			end
		end
		issue(CMD_QUERY, $urandom_range(DEPTH - 1), x, y, z);
	endtask

	initial begin
		int entries;
		int gsize;
		int gused;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_settings(8, 8, 8, DIST_MAX);
		issue(CMD_LOAD, 0, PT_MIN, PT_MIN, PT_MIN);
		issue(CMD_LOAD, 1, 100, 200, 300);
		issue(CMD_LOAD, 2, PT_MAX, PT_MAX, PT_MAX);
		issue(CMD_LOAD, 3, 100, 200, 300);
		issue(CMD_LOAD, 4, 0, 0, 0);
		issue(CMD_LOAD, 5, -1, -1, -1);
		issue(CMD_LOAD, 6, 101, 200, 300);
		issue(CMD_LOAD, 7, PT_MIN, PT_MAX, 0);
		issue(CMD_LOAD, DEPTH - 1, 1, 2, 3);
		issue(CMD_QUERY, 0, PT_MAX, PT_MAX, PT_MAX);
		issue(CMD_QUERY, DEPTH - 1, PT_MAX, PT_MIN, PT_MAX);
		issue(CMD_QUERY, 0, 100, 200, 301);
		issue(CMD_QUERY, 0, 0, 0, 1);
		apply_settings(8, 8, 8, '0);
		issue(CMD_QUERY, 0, 5, 5, 5);
		issue(CMD_QUERY, 0, 100, 200, 300);
		apply_settings(0, 0, 0, LIMIT_RESET);
		issue(CMD_QUERY, 0, 0, 0, 0);
		apply_settings(2047, 0, 0, DIST_MAX);
		issue(CMD_QUERY, DEPTH - 1, 100, 200, 300);

		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 4)
				1: idle_pct = 55;
				3: idle_pct = 38;
				default: idle_pct = 0;
			endcase
			case (ph)
				0: apply_settings(16, 8, 8, DIST_MAX);
				1: apply_settings(3, 0, 1, '0);
				2: apply_settings(64, 16, 1, LIMIT_RESET);
				3: apply_settings(40, 5, 31, DIST_W'(2000));
				4: apply_settings(1024, 16, 1, DIST_MAX);
				5: apply_settings(2047, 31, 1, pick_limit());
				6: apply_settings(1000, 31, 2, pick_limit());
				default: begin
					case ($urandom_range(19)) inside
						[0:12]:  entries = $urandom_range(128, 1);
						[13:15]: entries = $urandom_range(1024, 129);
						[16:17]: entries = 0;
						default: entries = $urandom_range(2047, 1025);
					endcase
					gsize = $urandom_range(31);
					gused = ($urandom_range(1) == 1) ? $urandom_range(gsize) : $urandom_range(31);
					// keep large scans sparse so the table fill stays short
					if (entries > 128) begin
						gsize = $urandom_range(31, 16);
						gused = $urandom_range(2);
					end
					apply_settings(entries, gsize, gused, pick_limit());
				end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++)
				if ($urandom_range(99) < 40)
					random_load();
				else
					random_search();
		end

		settle();
		$display("%0d transfers: %0d table loads and %0d searches under %0d register settings",
			loads_sent + searches_sent, loads_sent, searches_sent, settings_used);
		$display("%0d search results checked, %0d with a match, %0d of them exact",
			searches_checked, searches_hit, searches_exact);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
